[src/zscore_feature_normalizer_macros.svh]
// assertion macros shared by the normalizer modules
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ZSCORE_FEATURE_NORMALIZER_MACROS_SVH
`define ZSCORE_FEATURE_NORMALIZER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ZFN_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("zfn: forbidden condition seen");
`define ZFN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("zfn: expected follow-up missing");
`else
`define ZFN_ASSERT_NEVER(lbl, clk, rstn, expr)
`define ZFN_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[src/zfn_pkg.sv]
// shared types and constants of the z-score normalizer
// no dependencies
package zfn_pkg;
	localparam int NS_W = 11;
	localparam logic [NS_W-1:0] NS_RESET = 11'd1024;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	typedef struct packed {
		logic load;
		logic mean_start;
		logic mean_latch;
		logic sq_clear;
		logic sq_read;
		logic take_diff;
		logic sq_mul;
		logic sq_acc;
		logic var_start;
		logic sqrt_start;
		logic std_latch;
		logic ediv_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic col_done;
		logic sq_last;
		logic emit_last;
	} sts_t;
endpackage

[src/zfn_if.sv]
// channel interfaces: input requests, results, configuration writes
// depends on nothing
interface zfn_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic signed [31:0] sample;
	modport source(output valid, opcode, sample, input ready);
	modport sink(input valid, opcode, sample, output ready);
endinterface

interface zfn_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] normalized;
	logic last_of_column;
	modport source(output valid, normalized, last_of_column, input ready);
	modport sink(input valid, normalized, last_of_column, output ready);
endinterface

interface zfn_cfg_if;
	logic valid;
	logic ready;
	logic [10:0] col_len;
	modport source(output valid, col_len, input ready);
	modport sink(input valid, col_len, output ready);
endinterface

[src/zfn_ram.sv]
// generic single-port ram with registered read
// no dependencies
module zfn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[src/zfn_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
// dividend comes left-aligned; quotient ends in the low iters bits
module zfn_div #(
	parameter int DW = 75,
	parameter int VW = 32,
	parameter int IW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	input  logic [IW-1:0] iters,
	output logic          busy,
	output logic [DW-1:0] quotient
);
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dv_q;
	logic [DW-1:0] dq_q;
	logic [IW-1:0] cnt_q;
	logic          busy_q;
	logic [VW:0]   sh;
	logic [VW:0]   trial;
	logic          ge;

	assign sh    = {rem_q, dq_q[DW-1]};
	assign ge    = sh >= {1'b0, dv_q};
	assign trial = sh - {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dv_q  <= divisor;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? trial[VW-1:0] : sh[VW-1:0];
			dq_q  <= {dq_q[DW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;
endmodule

[src/zfn_datapath.sv]
// datapath: sample store, sums, mean, deviation, square root, output register
// depends on zfn_pkg, zfn_ram, zfn_div
`include "zscore_feature_normalizer_macros.svh"
module zfn_datapath import zfn_pkg::*; #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_we,
	input  logic [NS_W-1:0]    cfg_data,
	input  logic signed [31:0] sample,
	output logic signed [31:0] normalized,
	output logic               last_of_column
);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int SW = 32 + CW;
	localparam int DW = 64 + CW;
	localparam int IW = $clog2(DW + 1);
	localparam int NW = (CW > NS_W) ? CW : NS_W;
	localparam logic [NW-1:0] MAX_N = NW'(MAX_SAMPLES);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_SAMPLES);

	logic [NS_W-1:0]     col_len_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       idx_q;
	logic signed [SW-1:0] sum_q;
	logic signed [31:0]  mean_q;
	logic [31:0]         std_q;
	logic [DW-1:0]       acc_q;
	logic [31:0]         m_q;
	logic                neg_q;
	logic [63:0]         sq_q;
	logic signed [31:0]  normalized_q;
	logic                last_q;

	logic [NW-1:0]  ns_w;
	logic [NW-1:0]  n_eff;
	logic           room;
	logic [CW-1:0]  cnt_next;
	logic           ram_we;
	logic [AW-1:0]  ram_addr;
	logic [31:0]    ram_rdata;
	logic [32:0]    diff;
	logic [32:0]    mag;
	logic           sum_neg;
	logic [SW-1:0]  sum_mag;
	logic           div_start;
	logic [DW-1:0]  div_dividend;
	logic [31:0]    div_divisor;
	logic [IW-1:0]  div_iters;
	logic           div_busy;
	logic [DW-1:0]  quot;
	logic [31:0]    q_neg;
	logic [31:0]    q_pos;
	logic           emit_last;
	logic           sq_last;

	// square root: two radicand bits per step
	logic [63:0] sx_q;
	logic [34:0] srem_q;
	logic [31:0] sroot_q;
	logic [5:0]  scnt_q;
	logic        sbusy_q;
	logic [34:0] sr2;
	logic [34:0] strial;
	logic        sge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_len_q <= NS_RESET;
		end else if (cfg_we) begin
			col_len_q <= cfg_data;
		end
	end

	assign ns_w     = NW'(col_len_q);
	assign n_eff    = (ns_w == '0) ? NW'(1) : ((ns_w > MAX_N) ? MAX_N : ns_w);
	assign room     = count_q < MAX_C;
	assign cnt_next = count_q + CW'(room);
	assign emit_last = CW'(ptr_q + 1'b1) == count_q;
	assign sq_last   = CW'(idx_q + 1'b1) == count_q;

	assign ram_we   = cmd.load & room;
	assign ram_addr = cmd.load ? count_q[AW-1:0] :
		(cmd.sq_read ? idx_q[AW-1:0] : ptr_q[AW-1:0]);

	zfn_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(sample),
		.rdata(ram_rdata)
	);

	assign diff = {ram_rdata[31], ram_rdata} - {mean_q[31], mean_q};
	assign mag  = diff[32] ? (33'd0 - diff) : diff;

	assign sum_neg = sum_q[SW-1];
	assign sum_mag = sum_neg ? SW'(-sum_q) : SW'(sum_q);

	assign div_start = cmd.mean_start | cmd.var_start | cmd.ediv_start;
	always_comb begin
		div_dividend = acc_q;
		div_divisor  = 32'(count_q);
		div_iters    = IW'(DW);
		if (cmd.mean_start) begin
			div_dividend = {sum_mag, 32'd0};
			div_iters    = IW'(SW);
		end else if (cmd.ediv_start) begin
			div_dividend = {m_q, 16'd0, (DW - 48)'(0)};
			div_divisor  = std_q;
			div_iters    = IW'(48);
		end
	end

	zfn_div #(.DW(DW), .VW(32), .IW(IW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.iters   (div_iters),
		.busy    (div_busy),
		.quotient(quot)
	);

	// saturate the quotient magnitude to the signed q16.16 range
	assign q_neg = (quot[47:0] > 48'h0000_8000_0000) ? 32'h8000_0000 : quot[31:0];
	assign q_pos = (quot[47:0] > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];

	assign sr2    = {srem_q[32:0], sx_q[63:62]};
	assign strial = {1'b0, sroot_q, 2'b01};
	assign sge    = sr2 >= strial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbusy_q <= 1'b0;
			scnt_q  <= '0;
		end else if (cmd.sqrt_start) begin
			sbusy_q <= 1'b1;
			scnt_q  <= 6'd32;
		end else if (sbusy_q) begin
			scnt_q  <= scnt_q - 1'b1;
			sbusy_q <= scnt_q != 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sx_q    <= quot[63:0];
			srem_q  <= '0;
			sroot_q <= '0;
		end else if (sbusy_q) begin
			sx_q    <= {sx_q[61:0], 2'b00};
			srem_q  <= sge ? (sr2 - strial) : sr2;
			sroot_q <= {sroot_q[30:0], sge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			ptr_q   <= '0;
			idx_q   <= '0;
			mean_q  <= '0;
			std_q   <= ONE_Q16;
		end else begin
			if (cmd.load) begin
				if (room) begin
					count_q <= cnt_next;
					sum_q   <= sum_q + SW'(sample);
				end
			end else if (cmd.out_load) begin
				if (emit_last) begin
					count_q <= '0;
					sum_q   <= '0;
					ptr_q   <= '0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			if (cmd.mean_latch) begin
				mean_q <= sum_neg ? (32'sd0 - $signed(quot[31:0])) : $signed(quot[31:0]);
			end
			if (cmd.sq_clear) begin
				idx_q <= '0;
			end else if (cmd.sq_acc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.std_latch) begin
				std_q <= (sroot_q == '0) ? ONE_Q16 : sroot_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_diff) begin
			m_q   <= mag[31:0];
			neg_q <= diff[32];
		end
		if (cmd.sq_mul) begin
			sq_q <= m_q * m_q;
		end
		if (cmd.sq_clear) begin
			acc_q <= '0;
		end else if (cmd.sq_acc) begin
			acc_q <= acc_q + DW'(sq_q);
		end
		if (cmd.out_load) begin
			normalized_q <= neg_q ? $signed(32'd0 - q_neg) : $signed(q_pos);
			last_q       <= emit_last;
		end
	end

	assign sts.div_busy  = div_busy;
	assign sts.sqrt_busy = sbusy_q;
	assign sts.col_done  = NW'(cnt_next) >= n_eff;
	assign sts.sq_last   = sq_last;
	assign sts.emit_last = emit_last;

	assign normalized     = normalized_q;
	assign last_of_column = last_q;

	`ZFN_ASSERT_NEVER(a_ptr_in_column, clk, arst_n, ptr_q > count_q)
	`ZFN_ASSERT_NEVER(a_std_nonzero, clk, arst_n, std_q == '0)
	`ZFN_ASSERT_NEVER(a_count_in_range, clk, arst_n, count_q > MAX_C)
endmodule

[src/zfn_ctrl.sv]
// controller: sequences loading, column statistics and emitting
// depends on zfn_pkg
`include "zscore_feature_normalizer_macros.svh"
module zfn_ctrl import zfn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_op,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);
	typedef enum logic [3:0] {
		S_LOAD, S_MEAN, S_MEAN_W, S_SQ_RD, S_SQ_SUB, S_SQ_MUL, S_SQ_ACC,
		S_VAR, S_VAR_W, S_SQRT_W, S_EMIT, S_E_SUB, S_E_DIV, S_E_W, S_E_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready = (state_q == S_LOAD) || (state_q == S_EMIT);
	assign accept   = in_valid & in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_LOAD) && accept && (in_op == OP_LOAD);
		cmd.mean_start = state_q == S_MEAN;
		cmd.mean_latch = (state_q == S_MEAN_W) && !sts.div_busy;
		cmd.sq_clear   = cmd.mean_latch;
		cmd.sq_read    = state_q == S_SQ_RD;
		cmd.take_diff  = (state_q == S_SQ_SUB) || (state_q == S_E_SUB);
		cmd.sq_mul     = state_q == S_SQ_MUL;
		cmd.sq_acc     = state_q == S_SQ_ACC;
		cmd.var_start  = state_q == S_VAR;
		cmd.sqrt_start = (state_q == S_VAR_W) && !sts.div_busy;
		cmd.std_latch  = (state_q == S_SQRT_W) && !sts.sqrt_busy;
		cmd.ediv_start = state_q == S_E_DIV;
		cmd.out_load   = (state_q == S_E_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (cmd.load && sts.col_done) begin
						state_q <= S_MEAN;
					end
				end
				S_MEAN: state_q <= S_MEAN_W;
				S_MEAN_W: begin
					if (!sts.div_busy) begin
						state_q <= S_SQ_RD;
					end
				end
				S_SQ_RD: state_q <= S_SQ_SUB;
				S_SQ_SUB: state_q <= S_SQ_MUL;
				S_SQ_MUL: state_q <= S_SQ_ACC;
				S_SQ_ACC: begin
					state_q <= sts.sq_last ? S_VAR : S_SQ_RD;
				end
				S_VAR: state_q <= S_VAR_W;
				S_VAR_W: begin
					if (!sts.div_busy) begin
						state_q <= S_SQRT_W;
					end
				end
				S_SQRT_W: begin
					if (!sts.sqrt_busy) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// a load request here is taken and dropped
					if (accept && (in_op == OP_EMIT)) begin
						state_q <= S_E_SUB;
					end
				end
				S_E_SUB: state_q <= S_E_DIV;
				S_E_DIV: state_q <= S_E_W;
				S_E_W: begin
					if (!sts.div_busy) begin
						state_q <= S_E_OUT;
					end
				end
				S_E_OUT: begin
					if (out_free) begin
						state_q <= sts.emit_last ? S_LOAD : S_EMIT;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	`ZFN_ASSERT_NEXT(a_div_starts, clk, arst_n, cmd.mean_start, sts.div_busy)
	`ZFN_ASSERT_NEVER(a_out_after_div, clk, arst_n, cmd.out_load && sts.div_busy)
	`ZFN_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid_q && !out_ready, out_valid_q)
endmodule

[src/zscore_feature_normalizer.sv]
// Z-score normalizer for one feature column. The load request (opcode 0) that
// completes the column starts the statistics pass: a mean division, the
// squared deviations of the stored samples (one store read each), a variance
// division and a square root. Each emit request (opcode 1) then runs a 48-step
// division on the shared radix-2 divider; the next request is taken once the
// result sits in the output register. Results wait in that register, so the
// next request is taken while a result is still unread.
// depends on zfn_pkg, zfn_if, zfn_ctrl, zfn_datapath
module zscore_feature_normalizer import zfn_pkg::*; #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	zfn_in_if.sink    in_ch,
	zfn_out_if.source out_ch,
	zfn_cfg_if.sink   cfg_ch
);
	cmd_t cmd;
	sts_t sts;

	assign cfg_ch.ready = 1'b1;

	zfn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_op    (in_ch.opcode),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	zfn_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_ch.valid),
		.cfg_data      (cfg_ch.col_len),
		.sample        (in_ch.sample),
		.normalized    (out_ch.normalized),
		.last_of_column(out_ch.last_of_column)
	);
endmodule

[bench/zscore_feature_normalizer_tb.sv]
`timescale 1ns / 100ps
// testbench for the z-score column normalizer: loads columns, emits normalized values
// and checks each result against a behavioral predictor; depends on zfn_pkg, zfn_if, zscore_feature_normalizer
module zscore_feature_normalizer_tb import zfn_pkg::*; ();

	localparam int MAX_N = 1024;

	logic clk;
	logic arst_n;

	zfn_in_if  in_ch();
	zfn_out_if out_ch();
	zfn_cfg_if cfg_ch();

	zscore_feature_normalizer #(.MAX_SAMPLES(MAX_N)) u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	typedef struct packed {
		logic [31:0] normalized;
		logic        last_of_column;
	} norm_result_t;

	// predictor state
	logic [31:0]        col_store [MAX_N];
	int unsigned        col_count;
	longint             col_sum;
	longint             col_mean;
	logic [31:0]        col_std;
	int unsigned        emit_idx;
	bit                 emitting;
	logic [10:0]        n_reg;

	norm_result_t       pending_results[$];
	int                 errors;
	int                 results_seen;
	int                 columns_done;
	int                 send_idle_pct;
	int                 recv_idle_pct;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint unsigned root64(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'h1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	task automatic close_column();
		logic [127:0] sq_total;
		logic [127:0] varq;
		longint d;
		longint unsigned m;
		longint unsigned r;
		sq_total = '0;
		col_mean = col_sum / longint'(col_count);
		for (int i = 0; i < col_count; i++) begin
			d = longint'($signed(col_store[i])) - col_mean;
			m = (d < 0) ? longint'(-d) : longint'(d);
			sq_total = sq_total + {64'd0, m * m};
		end
		varq = sq_total / col_count;
		r = root64(varq[63:0]);
		col_std = r[31:0];
		if (col_std == 0)
			col_std = ONE_Q16;
		emit_idx = 0;
		emitting = 1'b1;
		columns_done++;
	endtask

	// advance the predictor by one accepted request
	task automatic predict_request(input logic op, input logic [31:0] value);
		int unsigned lim;
		longint d;
		longint unsigned m, qm;
		norm_result_t r;
		if (op == OP_LOAD) begin
			if (emitting)
				return;
			lim = n_reg;
			if (lim < 1)
				lim = 1;
			if (lim > MAX_N)
				lim = MAX_N;
			if (col_count < MAX_N) begin
				col_store[col_count] = value;
				col_sum += longint'($signed(value));
				col_count++;
			end
			if (col_count >= lim)
				close_column();
			return;
		end
		if (!emitting || emit_idx >= col_count)
			return;
		d = longint'($signed(col_store[emit_idx])) - col_mean;
		m = (d < 0) ? longint'(-d) : longint'(d);
		qm = (m << 16) / col_std;
		if (d < 0) begin
			if (qm > 64'h8000_0000)
				qm = 64'h8000_0000;
			r.normalized = 32'(64'h1_0000_0000 - qm);
		end else begin
			if (qm > 64'h7FFF_FFFF)
				qm = 64'h7FFF_FFFF;
			r.normalized = qm[31:0];
		end
		r.last_of_column = (emit_idx + 1 == col_count);
		pending_results.push_back(r);
		emit_idx++;
		if (r.last_of_column) begin
			emitting = 1'b0;
			col_count = 0;
			col_sum = 0;
			emit_idx = 0;
		end
	endtask

	// valid stays up after a request until the next one, an idle gap or a drain
	task automatic send_request(input logic op, input logic [31:0] value);
		if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99, 0) < send_idle_pct);
		end
		in_ch.valid  <= 1'b1;
		in_ch.opcode <= op;
		in_ch.sample <= value;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_request(op, value);
	endtask

	// wait until all results have been taken, then let the block settle
	task automatic drain();
		int guard;
		guard = 0;
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
	endtask

	task automatic write_count(input logic [10:0] value);
		drain();
		cfg_ch.valid   <= 1'b1;
		cfg_ch.col_len <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		n_reg = value;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic emit_all();
		for (int i = 0; i < col_count; i++)
			send_request(OP_EMIT, 32'd0);
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(5, 0))
			0: return $urandom;
			1: return 32'h7FFF_FFFF - $urandom_range(3, 0);
			2: return 32'h8000_0000 + $urandom_range(3, 0);
			default: return 32'($signed($urandom_range(2000000, 0)) - 1000000);
		endcase
	endfunction

	task automatic test_extremes();
		write_count(11'd4);
		send_request(OP_EMIT, 32'd0);            // emit while loading: ignored
		send_request(OP_LOAD, 32'h7FFF_FFFF);
		send_request(OP_LOAD, 32'h8000_0000);
		send_request(OP_LOAD, 32'h0000_0000);
		send_request(OP_LOAD, 32'hFFFF_FFFF);
		send_request(OP_LOAD, 32'h1234_5678);    // load while emitting: ignored
		emit_all();
		send_request(OP_EMIT, 32'd0);            // nothing left: ignored
	endtask

	task automatic test_flat_column();
		// zero deviation falls back to one
		write_count(11'd3);
		repeat (3) send_request(OP_LOAD, 32'h0003_0000);
		emit_all();
		write_count(11'd1);
		send_request(OP_LOAD, 32'h8000_0000);
		emit_all();
		write_count(11'd0);                      // zero counts as one
		send_request(OP_LOAD, 32'h0000_0001);
		emit_all();
		// tiny spread below resolution
		write_count(11'd2);
		send_request(OP_LOAD, 32'h0000_0000);
		send_request(OP_LOAD, 32'h0000_0001);
		emit_all();
	endtask

	task automatic test_oversize_count();
		// above the store depth the count is clamped, giving a full column
		write_count(11'h7FF);
		for (int i = 0; i < MAX_N; i++)
			send_request(OP_LOAD, rand_sample());
		emit_all();
	endtask

	task automatic test_random_columns(input int items);
		int sent, n, k;
		sent = 0;
		while (sent < items) begin
			n = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1);
			write_count(11'(n));
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(15, 0) == 0) begin
					send_request(OP_EMIT, $urandom);  // noise while loading
					sent++;
				end
				send_request(OP_LOAD, rand_sample());
				sent++;
			end
			k = col_count;
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(15, 0) == 0)
					send_request(OP_LOAD, $urandom);  // noise while emitting
				send_request(OP_EMIT, $urandom);
				sent++;
			end
		end
	endtask

	task automatic test_midcolumn_write();
		// shrink the count after loads: next load closes the column
		write_count(11'd10);
		repeat (5) send_request(OP_LOAD, rand_sample());
		in_ch.valid    <= 1'b0;
		cfg_ch.valid   <= 1'b1;
		cfg_ch.col_len <= 11'd3;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		n_reg = 11'd3;
		cfg_ch.valid <= 1'b0;
		send_request(OP_LOAD, rand_sample());
		emit_all();
	endtask

	// receiver: random back-pressure, checks each result in order
	always @(posedge clk) begin
		norm_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result normalized=%h last=%b", $time,
					out_ch.normalized, out_ch.last_of_column);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (want.normalized !== out_ch.normalized) begin
					$display("%0t: normalized expected %h actual %h", $time,
						want.normalized, out_ch.normalized);
					errors++;
				end
				if (want.last_of_column !== out_ch.last_of_column) begin
					$display("%0t: last_of_column expected %b actual %b", $time,
						want.last_of_column, out_ch.last_of_column);
					errors++;
				end
			end
		end
		out_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
	end

	initial begin
		clk = 1'b0;
		errors = 0;
		results_seen = 0;
		columns_done = 0;
		col_count = 0;
		col_sum = 0;
		col_mean = 0;
		col_std = ONE_Q16;
		emit_idx = 0;
		emitting = 1'b0;
		n_reg = NS_RESET;
		send_idle_pct = 16;
		recv_idle_pct = 47;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_LOAD;
		in_ch.sample = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.col_len = NS_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_flat_column();
		test_midcolumn_write();
		test_random_columns(60);
		send_idle_pct = 47;
		recv_idle_pct = 16;
		test_oversize_count();
		test_random_columns(60);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_columns(60);
		drain();

		$display("covered %0d columns and %0d results, column sizes 1 to 1024,", columns_done,
			results_seen);
		$display("extreme samples, flat columns, ignored requests and mid-column count change");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("simulation failed");
		$finish;
	end
endmodule

[files.f]
+incdir+src
src/zfn_pkg.sv
src/zfn_if.sv
src/zfn_ram.sv
src/zfn_div.sv
src/zfn_datapath.sv
src/zfn_ctrl.sv
src/zscore_feature_normalizer.sv
bench/zscore_feature_normalizer_tb.sv
